// ----- src/fnv_chained_hash_table_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef FNV_CHAINED_HASH_TABLE_UNIT_DEFINES_SVH
`define FNV_CHAINED_HASH_TABLE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FCHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcht assertion failed");

// antecedent implies consequent in the next cycle
`define FCHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcht assertion failed");

`endif

// ----- src/fcht_pkg.sv -----
// ----------------------------------------------------------------------------
// fcht_pkg
// types and status codes of the chained hash table unit
// ----------------------------------------------------------------------------
`default_nettype none

package fcht_pkg;

  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_HIT      = 3'd2;
  localparam logic [2:0] ST_MISS     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] value_in;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [10:0] entry_count;
  } out_beat_t;

  // hash unit result
  typedef struct packed {
    logic        done;
    logic [31:0] hash;
  } hash_res_t;

endpackage

`default_nettype wire

// ----- src/fcht_hash.sv -----
// ----------------------------------------------------------------------------
// fcht_hash
// iterative fnv-1 32-bit hash, one key byte per cycle, low byte first
// ----------------------------------------------------------------------------
`default_nettype none

module fcht_hash (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [31:0]       key,
  output fcht_pkg::hash_res_t    res
);
  import fcht_pkg::*;

  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;

  logic [31:0] h;
  logic [31:0] key_r;
  logic [1:0]  idx;
  logic        busy;
  logic        done;
  logic [31:0] h_next;
  logic [7:0]  cur_byte;

  // multiply by 0x01000193 as shift-add, then fold in the byte
  always_comb begin
    cur_byte = key_r[8*idx +: 8];
    h_next   = ((h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h)
               ^ {24'd0, cur_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        idx   <= 2'd0;
        h     <= FNV_BASIS;
        key_r <= key;
      end else if (busy) begin
        h   <= h_next;
        idx <= idx + 2'd1;
        if (idx == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.hash = h;

endmodule

`default_nettype wire

// ----- src/fcht_mem.sv -----
// ----------------------------------------------------------------------------
// fcht_mem
// slot memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fcht_mem #(
  parameter int DEPTH = 1280,
  parameter int AW    = 11,
  parameter int DW    = 75
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  import fcht_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/fnv_chained_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// fnv_chained_hash_table_unit
// fnv-1 hashed key/value store with chained overflow nodes in one slot memory
// ----------------------------------------------------------------------------
// timing: the walk covers the byte-serial hash, one slot memory read per chain
//   node (the head first, then each pool node walked past it) and, for a put
//   that appends a pool node, the append state
// throughput: one item at a time; the next beat is taken once the result
//   sits in the output register
// reset: synchronous; afterwards a clearing pass zeroes all BUCKETS bucket
//   head slots, and no input beat is taken during it
`default_nettype none

module fnv_chained_hash_table_unit #(
  parameter int BUCKETS     = 1024,
  parameter int POOL_NODES  = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fcht_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fcht_pkg::out_beat_t      out_data
);
  import fcht_pkg::*;

  // derived sizes
  localparam int SLOTS = BUCKETS + POOL_NODES;
  localparam int AW    = $clog2(SLOTS);
  localparam int BW    = $clog2(BUCKETS);
  localparam int LW    = $clog2(POOL_NODES + 1);
  localparam int SW    = $clog2(POOL_NODES + 2);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int SVW   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int DW    = 1 + 32 + SVW + LW;

  // state codes
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_LOOK   = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [BW-1:0]  clr_idx;

  // item held during its walk
  logic           is_get;
  logic [31:0]    key_r;
  logic [SVW-1:0] val_r;
  logic [AW-1:0]  cur_addr;
  logic [SW-1:0]  steps;

  // table bookkeeping
  logic [LW-1:0]  pool_free;
  logic [CW-1:0]  keys_held;

  // result waiting for the output register
  logic [2:0]     res_status;
  logic [SVW-1:0] res_value;

  // memory port
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [DW-1:0]  mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [DW-1:0]  mem_rdata;

  hash_res_t      hres;
  logic           hash_start;

  // fields of the slot just read
  logic           rd_valid;
  logic [31:0]    rd_key;
  logic [SVW-1:0] rd_val;
  logic [LW-1:0]  rd_link;
  logic           rd_hit;
  logic           rd_end;
  logic           pool_avail;
  logic [AW-1:0]  link_addr;
  logic [AW-1:0]  new_addr;
  logic [AW-1:0]  bucket_addr;
  logic           out_free;

  assign rd_valid = mem_rdata[DW-1];
  assign rd_key   = mem_rdata[LW+SVW +: 32];
  assign rd_val   = mem_rdata[LW +: SVW];
  assign rd_link  = mem_rdata[LW-1:0];

  assign rd_hit     = rd_valid && (rd_key == key_r);
  // chain ends at an empty slot, a null link, a link outside the pool, or a walk longer than the pool
  assign rd_end     = !rd_valid || (rd_link == '0) || (LW'(POOL_NODES) < rd_link)
                      || (SW'(POOL_NODES) < steps);
  assign pool_avail = pool_free < LW'(POOL_NODES);

  assign link_addr   = AW'(BUCKETS) + AW'(rd_link) - AW'(1);
  // pool_free already counts the node handed out in the look cycle
  assign new_addr    = AW'(BUCKETS) + AW'(pool_free) - AW'(1);
  assign bucket_addr = AW'(hres.hash[BW-1:0]);

  assign in_ready   = (state == S_IDLE);
  assign hash_start = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;

  fcht_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (in_data.key),
    .res   (hres)
  );

  fcht_mem #(
    .DEPTH (SLOTS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // memory access and next state
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cur_addr;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = cur_addr;
    unique case (state)
      S_CLEAR: begin
        // zero one bucket head per cycle
        mem_we    = 1'b1;
        mem_waddr = AW'(clr_idx);
        if (clr_idx == BW'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (hash_start) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (hres.done) begin
          mem_re     = 1'b1;
          mem_raddr  = bucket_addr;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!rd_hit && !rd_end) begin
          // follow the link to the next pool node
          mem_re    = 1'b1;
          mem_raddr = link_addr;
        end else begin
          state_next = S_DONE;
          if (is_get == FUNC_PUT) begin
            if (rd_hit) begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, rd_key, val_r, rd_link};
            end else if (!rd_valid) begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, key_r, val_r, LW'(0)};
            end else if (pool_avail) begin
              // hook the tail onto the next free node
              mem_we     = 1'b1;
              mem_wdata  = {1'b1, rd_key, rd_val, pool_free + LW'(1)};
              state_next = S_APPEND;
            end
          end
        end
      end
      S_APPEND: begin
        mem_we     = 1'b1;
        mem_waddr  = new_addr;
        mem_wdata  = {1'b1, key_r, val_r, LW'(0)};
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      pool_free <= '0;
      keys_held <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + BW'(1);
      end
      if (hash_start) begin
        is_get <= in_data.func;
        key_r  <= in_data.key;
        val_r  <= SVW'(in_data.value_in);
      end
      if (mem_re) begin
        cur_addr <= mem_raddr;
        steps    <= (state == S_HASH) ? SW'(0) : steps + SW'(1);
      end
      if (state == S_LOOK && (rd_hit || rd_end)) begin
        res_value <= '0;
        if (is_get == FUNC_GET) begin
          if (rd_hit) begin
            res_status <= ST_HIT;
            res_value  <= rd_val;
          end else begin
            res_status <= ST_MISS;
          end
        end else if (rd_hit) begin
          res_status <= ST_UPDATED;
          res_value  <= val_r;
        end else if (!rd_valid) begin
          res_status <= ST_INSERTED;
          res_value  <= val_r;
          keys_held  <= keys_held + CW'(1);
        end else if (pool_avail) begin
          res_status <= ST_INSERTED;
          res_value  <= val_r;
          keys_held  <= keys_held + CW'(1);
          pool_free  <= pool_free + LW'(1);
        end else begin
          res_status <= ST_FULL;
        end
      end
      // output register: load when free, drop when taken
      if (state == S_DONE && out_free) begin
        out_valid             <= 1'b1;
        out_data.status       <= res_status;
        out_data.value_out    <= 32'(res_value);
        out_data.entry_count  <= 11'(keys_held);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/fcht_checker.sv -----
// ----------------------------------------------------------------------------
// fcht_checker
// port-level checks of the chained hash table unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "fnv_chained_hash_table_unit_defines.svh"

module fcht_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire fcht_pkg::in_beat_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire fcht_pkg::out_beat_t out_data
);
  import fcht_pkg::*;

  logic in_beat;
  logic miss_or_full;

  assign in_beat      = in_valid && in_ready;
  assign miss_or_full = (out_data.status == ST_MISS) || (out_data.status == ST_FULL);

  // a stalled result holds
  `FCHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // one item at a time
  `FCHT_ASSERT_NEXT(a_one_item, in_beat, !in_ready)

  // miss and pool full carry a zero value
  `FCHT_ASSERT_NOW(a_zero_value, out_valid && miss_or_full, out_data.value_out == 32'd0)

  // a result never shows up the cycle after a beat is taken
  `FCHT_ASSERT_NEXT(a_no_early, in_beat && !out_valid, !out_valid)

endmodule

bind fnv_chained_hash_table_unit fcht_checker u_fcht_checker (.*);

`default_nettype wire
